// ===== sv/hpti_pkg.sv =====
// ----------------------------------------------------------------------------
// hpti_pkg: shared types and constants for the hashed page table insert
// Field widths, PTE bit positions, register indexes and placement codes.
// ----------------------------------------------------------------------------
package hpti_pkg;

    localparam int EA_W      = 32;
    localparam int PA_W      = 32;
    localparam int MODE_W    = 9;
    localparam int GROUP_W   = 10;
    localparam int SLOT_W    = 3;
    localparam int PLACE_W   = 2;
    localparam int WORD_W    = 32;
    localparam int PAGE_W    = 20;
    localparam int VSID_W    = 24;
    localparam int SEG_W     = 4;
    localparam int API_W     = 6;
    localparam int OFFSET_W  = 12;
    localparam int PTE_W     = 2 * WORD_W;
    localparam int SLOTS     = 8;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_MASK = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_VSID_BASE  = CFG_IDX_W'(1);

    localparam logic [GROUP_W-1:0] GROUP_MASK_RESET = 10'h3ff;
    localparam logic [VSID_W-1:0]  VSID_BASE_RESET  = 24'h000400;

    typedef enum logic [PLACE_W-1:0] {
        PLACE_MATCH = 2'd0,
        PLACE_FREE  = 2'd1,
        PLACE_EVICT = 2'd2
    } placement_t;

endpackage

// ===== sv/hpti_ram.sv =====
// ----------------------------------------------------------------------------
// hpti_ram: single-port RAM with registered read
// One access per cycle: a write, or a read whose data appears the next cycle.
// ----------------------------------------------------------------------------
module hpti_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/hashed_page_table_insert_32.sv =====
// ----------------------------------------------------------------------------
// hashed_page_table_insert_32: 32-bit hashed page table insert engine
// Hashes a faulting address into a PTE group and writes the new PTE pair.
// ----------------------------------------------------------------------------
// After reset the block clears the whole PTE table, one entry per cycle;
// requests are held off until then, while configuration writes are taken at
// any time. Each request then reads the eight entries of its group one by one
// through the single table port and compares each word zero in one shared
// comparator, writes the chosen entry back and presents the result. A new
// request is accepted only after the previous result has been registered at
// the output, so requests do not overlap; the single port of the PTE table
// sets the pace of the group scan.
// ----------------------------------------------------------------------------
module hashed_page_table_insert_32
    import hpti_pkg::*;
#(
    parameter int GROUP_COUNT = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [EA_W-1:0]       fault_address,
    input  logic [PA_W-1:0]       phys_address,
    input  logic [MODE_W-1:0]     mode_bits,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [GROUP_W-1:0]    group_index,
    output logic [SLOT_W-1:0]     slot_index,
    output logic [PLACE_W-1:0]    placement,
    output logic [WORD_W-1:0]     pte_high,
    output logic [WORD_W-1:0]     pte_low,
    output logic [PAGE_W-1:0]     invalidate_page
);

    localparam int GRP_W  = $clog2(GROUP_COUNT);
    localparam int ADDR_W = GRP_W + SLOT_W;
    localparam int DEPTH  = GROUP_COUNT * SLOTS;
    localparam logic [GROUP_W-1:0] TABLE_MASK = GROUP_W'(GROUP_COUNT - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [EA_W-1:0]      ea_reg, ea_next;
    logic [PA_W-1:0]      phys_reg, phys_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [SLOT_W:0]      scan_cnt_reg, scan_cnt_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]    cmp_slot_reg, cmp_slot_next;
    logic                 match_found_reg, match_found_next;
    logic [SLOT_W-1:0]    match_slot_reg, match_slot_next;
    logic                 free_found_reg, free_found_next;
    logic [SLOT_W-1:0]    free_slot_reg, free_slot_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    placement_t           place_reg, place_next;
    logic [SLOT_W-1:0]    victim_reg, victim_next;
    logic [GROUP_W-1:0]   group_mask_reg, group_mask_next;
    logic [VSID_W-1:0]    vsid_base_reg, vsid_base_next;
    logic                 out_valid_reg, out_valid_next;
    logic [GROUP_W-1:0]   group_index_reg, group_index_next;
    logic [SLOT_W-1:0]    slot_index_reg, slot_index_next;
    logic [PLACE_W-1:0]   placement_reg, placement_next;
    logic [WORD_W-1:0]    pte_high_reg, pte_high_next;
    logic [WORD_W-1:0]    pte_low_reg, pte_low_next;
    logic [PAGE_W-1:0]    inval_page_reg, inval_page_next;

    logic [VSID_W-1:0]          vsid;
    logic [WORD_W-1:0]          word0;
    logic [WORD_W-1:0]          word1;
    logic [GROUP_W-1:0]         group_idx;
    logic [GROUP_W+GRP_W-1:0]   group_ext;
    logic [GRP_W-1:0]           group_sel;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [PTE_W-1:0]     ram_wdata;
    logic [PTE_W-1:0]     ram_rdata;
    logic [WORD_W-1:0]    rd_word0;

    hpti_ram #(
        .WIDTH (PTE_W),
        .DEPTH (DEPTH)
    ) u_pte_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // PTE words and the hashed group for the request in hand
    assign vsid      = VSID_W'(ea_reg[EA_W-1 -: SEG_W]) + vsid_base_reg;
    assign word0     = {1'b1, vsid, 1'b0, ea_reg[EA_W-SEG_W-1 -: API_W]};
    assign word1     = {phys_reg[PA_W-1:OFFSET_W], 3'b000, mode_reg};
    assign group_idx = (vsid[GROUP_W-1:0] ^ ea_reg[OFFSET_W +: GROUP_W])
                       & group_mask_reg & TABLE_MASK;
    assign group_ext = {{GRP_W{1'b0}}, group_idx};
    assign group_sel = group_ext[GRP_W-1:0];
    assign rd_word0  = ram_rdata[PTE_W-1 -: WORD_W];

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        ea_next          = ea_reg;
        phys_next        = phys_reg;
        mode_next        = mode_reg;
        scan_cnt_next    = scan_cnt_reg;
        cmp_valid_next   = 1'b0;
        cmp_slot_next    = cmp_slot_reg;
        match_found_next = match_found_reg;
        match_slot_next  = match_slot_reg;
        free_found_next  = free_found_reg;
        free_slot_next   = free_slot_reg;
        slot_next        = slot_reg;
        place_next       = place_reg;
        victim_next      = victim_reg;
        group_mask_next  = group_mask_reg;
        vsid_base_next   = vsid_base_reg;
        out_valid_next   = out_valid_reg;
        group_index_next = group_index_reg;
        slot_index_next  = slot_index_reg;
        placement_next   = placement_reg;
        pte_high_next    = pte_high_reg;
        pte_low_next     = pte_low_reg;
        inval_page_next  = inval_page_reg;

        ram_we    = 1'b0;
        ram_addr  = {group_sel, scan_cnt_reg[SLOT_W-1:0]};
        ram_wdata = {word0, word1};

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GROUP_MASK: group_mask_next = cfg_data[GROUP_W-1:0];
                CFG_VSID_BASE:  vsid_base_next  = cfg_data[VSID_W-1:0];
                default: ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_addr      = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ea_next          = fault_address;
                    phys_next        = phys_address;
                    mode_next        = mode_bits;
                    scan_cnt_next    = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    state_next       = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // issue one slot read per cycle, compare it the cycle after
                if (!scan_cnt_reg[SLOT_W])
                begin
                    cmp_valid_next = 1'b1;
                    cmp_slot_next  = scan_cnt_reg[SLOT_W-1:0];
                    scan_cnt_next  = scan_cnt_reg + 1'b1;
                end
                if (cmp_valid_reg)
                begin
                    if (!match_found_reg && rd_word0 == word0)
                    begin
                        match_found_next = 1'b1;
                        match_slot_next  = cmp_slot_reg;
                    end
                    if (!free_found_reg && !rd_word0[WORD_W-1])
                    begin
                        free_found_next = 1'b1;
                        free_slot_next  = cmp_slot_reg;
                    end
                    if (scan_cnt_reg[SLOT_W])
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end

            ST_WRITE:
            begin
                if (match_found_reg)
                begin
                    slot_next  = match_slot_reg;
                    place_next = PLACE_MATCH;
                end
                else if (free_found_reg)
                begin
                    slot_next  = free_slot_reg;
                    place_next = PLACE_FREE;
                end
                else
                begin
                    slot_next   = victim_reg;
                    place_next  = PLACE_EVICT;
                    victim_next = victim_reg + 1'b1;
                end
                ram_we     = 1'b1;
                ram_addr   = {group_sel, slot_next};
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    group_index_next = group_idx;
                    slot_index_next  = slot_reg;
                    placement_next   = place_reg;
                    pte_high_next    = word0;
                    pte_low_next     = word1;
                    inval_page_next  = ea_reg[EA_W-1:OFFSET_W];
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            ea_reg          <= '0;
            phys_reg        <= '0;
            mode_reg        <= '0;
            scan_cnt_reg    <= '0;
            cmp_valid_reg   <= 1'b0;
            cmp_slot_reg    <= '0;
            match_found_reg <= 1'b0;
            match_slot_reg  <= '0;
            free_found_reg  <= 1'b0;
            free_slot_reg   <= '0;
            slot_reg        <= '0;
            place_reg       <= PLACE_MATCH;
            victim_reg      <= '0;
            group_mask_reg  <= GROUP_MASK_RESET;
            vsid_base_reg   <= VSID_BASE_RESET;
            out_valid_reg   <= 1'b0;
            group_index_reg <= '0;
            slot_index_reg  <= '0;
            placement_reg   <= '0;
            pte_high_reg    <= '0;
            pte_low_reg     <= '0;
            inval_page_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            ea_reg          <= ea_next;
            phys_reg        <= phys_next;
            mode_reg        <= mode_next;
            scan_cnt_reg    <= scan_cnt_next;
            cmp_valid_reg   <= cmp_valid_next;
            cmp_slot_reg    <= cmp_slot_next;
            match_found_reg <= match_found_next;
            match_slot_reg  <= match_slot_next;
            free_found_reg  <= free_found_next;
            free_slot_reg   <= free_slot_next;
            slot_reg        <= slot_next;
            place_reg       <= place_next;
            victim_reg      <= victim_next;
            group_mask_reg  <= group_mask_next;
            vsid_base_reg   <= vsid_base_next;
            out_valid_reg   <= out_valid_next;
            group_index_reg <= group_index_next;
            slot_index_reg  <= slot_index_next;
            placement_reg   <= placement_next;
            pte_high_reg    <= pte_high_next;
            pte_low_reg     <= pte_low_next;
            inval_page_reg  <= inval_page_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign group_index     = group_index_reg;
    assign slot_index      = slot_index_reg;
    assign placement       = placement_reg;
    assign pte_high        = pte_high_reg;
    assign pte_low         = pte_low_reg;
    assign invalidate_page = inval_page_reg;

endmodule
